// ===== hdl/mth_pkg.sv =====
`timescale 1ns / 1ps

package mth_pkg;

  // Bytes of lookahead needed to settle the flag of the oldest byte.
  localparam int LOOKAHEAD = 10;
  // Byte window: head plus lookahead, plus one slot of slack.
  localparam int WIN_DEPTH = LOOKAHEAD + 2;
  localparam int CNT_W     = 4;
  localparam int SKIP_W    = 4;

  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } win_entry_t;

  typedef struct packed {
    logic              token_active;
    logic [SKIP_W-1:0] skip_remaining;
    logic              prev_space;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{token_active: 1'b0,
                                         skip_remaining: '0,
                                         prev_space: 1'b1};

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_run_byte(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_DASH) || (c == CH_UNDER);
  endfunction

  function automatic logic is_sigil(input logic [7:0] c);
    return (c == CH_TILDE) || (c == CH_HASH) || (c == CH_AT);
  endfunction

endpackage

// ===== hdl/mth_scan.sv =====
`timescale 1ns / 1ps

// Decides the flag of the head byte from the lookahead window and the scan state.
module mth_scan (
  input  logic [mth_pkg::LOOKAHEAD:0][7:0] win_byte,
  input  logic [mth_pkg::LOOKAHEAD:0]      in_line,
  input  logic                             head_last,
  input  mth_pkg::scan_state_t             state,
  output logic                             mark,
  output mth_pkg::scan_state_t             state_nxt
);
  import mth_pkg::*;

  logic [7:0] head;
  logic       shape_ok;
  logic       date_ok;

  assign head = win_byte[0];

  // The ten bytes from the head must all belong to this line and read dddd-dd-dd.
  always_comb begin
    shape_ok = 1'b1;
    for (int i = 0; i < LOOKAHEAD; i++) begin
      shape_ok = shape_ok && in_line[i];
      if ((i == 4) || (i == 7)) begin
        shape_ok = shape_ok && (win_byte[i] == CH_DASH);
      end else begin
        shape_ok = shape_ok && is_digit(win_byte[i]);
      end
    end
  end

  // A date must be followed by a space, or by the end of the line.
  assign date_ok = shape_ok &&
                   (in_line[LOOKAHEAD] ? (win_byte[LOOKAHEAD] == CH_SPACE) : 1'b1);

  always_comb begin
    mark      = 1'b0;
    state_nxt = state;
    if (state.skip_remaining != '0) begin
      mark = 1'b1;
      state_nxt.skip_remaining = state.skip_remaining - SKIP_W'(1);
    end else if (state.token_active && is_run_byte(head)) begin
      mark = 1'b1;
    end else begin
      // Either no token was open, or this byte closes it and is scanned afresh.
      state_nxt.token_active = 1'b0;
      if (is_sigil(head)) begin
        mark = in_line[1] && is_run_byte(win_byte[1]);
        state_nxt.token_active = mark;
      end else if (is_digit(head) && state.prev_space) begin
        mark = date_ok;
        if (date_ok) begin
          state_nxt.skip_remaining = SKIP_W'(LOOKAHEAD - 1);
        end
      end
    end
    state_nxt.prev_space = (head == CH_SPACE);
    if (head_last) begin
      state_nxt = SCAN_RESET;
    end
  end

endmodule

// ===== hdl/meta_token_highlighter.sv =====
`timescale 1ns / 1ps

// Metadata token highlighter. Bytes of a text line enter one per transaction on the
// in_ channel, with in_line_end set on the final byte, and leave in the same order on
// the out_ channel, each with a highlight flag: set on every byte of a sigil token
// (~, # or @ followed by a run of letters, digits, '-' or '_') and of a yyyy-mm-dd date
// that stands between line start or a space and line end or a space. out_last marks
// the line's final byte. A byte is reported once the ten bytes after it are in the
// window, or once its line has ended, and the tail of a line drains one byte per
// cycle after the final byte arrives while out_stall is low. In steady flow the block
// takes one input transaction and gives one result transaction every cycle; the
// twelve-entry byte window and the output register let input continue while a result
// waits. in_stall rises only when the window is full, which happens only while
// out_stall holds results back.
module meta_token_highlighter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_line_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_highlight,
  output logic       out_last
);
  import mth_pkg::*;

  // Window of bytes not yet reported; entry 0 is the oldest (the head).
  win_entry_t            win_r   [WIN_DEPTH];
  win_entry_t            win_nxt [WIN_DEPTH];
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic [CNT_W-1:0]      wr_idx;
  scan_state_t           scan_r;
  scan_state_t           scan_nxt;

  logic                  out_valid_r;
  logic [7:0]            out_byte_r;
  logic                  out_highlight_r;
  logic                  out_last_r;

  logic [LOOKAHEAD:0][7:0] look_byte;
  logic [LOOKAHEAD:0]      in_line;
  logic                    any_last;
  logic                    decidable;
  logic                    push;
  logic                    pop;
  logic                    head_mark;

  // Work out which window entries still belong to the head byte's line. The first
  // stored line end closes the line; bytes behind it belong to the next one.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i <= LOOKAHEAD; i++) begin
      look_byte[i] = win_r[i].text;
      in_line[i]   = (CNT_W'(i) < cnt_r) && !seen;
      seen         = seen || ((CNT_W'(i) < cnt_r) && win_r[i].last);
    end
    any_last = seen;
  end

  // The head is settled once the full lookahead is present or its line has ended.
  assign decidable = (cnt_r >= CNT_W'(LOOKAHEAD + 1)) || any_last;

  assign in_stall = (cnt_r == CNT_W'(WIN_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = (cnt_r != '0) && decidable && (!out_valid_r || !out_stall);

  mth_scan u_scan (
    .win_byte  (look_byte),
    .in_line   (in_line),
    .head_last (win_r[0].last),
    .state     (scan_r),
    .mark      (head_mark),
    .state_nxt (scan_nxt)
  );

  // Shift the window down on a report and append the incoming byte behind the
  // entries that remain.
  assign wr_idx  = cnt_r - CNT_W'(pop);
  assign cnt_nxt = wr_idx + CNT_W'(push);

  always_comb begin
    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
      win_nxt[i] = pop ? win_r[i + 1] : win_r[i];
    end
    win_nxt[WIN_DEPTH - 1] = win_r[WIN_DEPTH - 1];
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (push && (wr_idx == CNT_W'(i))) begin
        win_nxt[i] = '{text: in_text_byte, last: in_line_end};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_r[i] <= win_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      scan_r      <= SCAN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) begin
        scan_r      <= scan_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; held while the downstream side stalls.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r      <= win_r[0].text;
      out_highlight_r <= head_mark;
      out_last_r      <= win_r[0].last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_highlight = out_highlight_r;
  assign out_last      = out_last_r;

endmodule

// ===== bench/meta_token_highlighter_tb.sv =====
`timescale 1ns / 1ps

// Each line of text is fed to the highlighter one byte per transaction, with the final
// byte flagged. Every accepted byte goes through a model of the scanner that is kept
// inside this module. The model adds the results that the byte releases to a queue of
// expected marked bytes. Each result that the block hands over is checked against the
// oldest entry of that queue.
module meta_token_highlighter_tb;
  import mth_pkg::*;

  // One byte of stimulus, and one reported byte with its flags.
  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } line_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       lit;
    logic       eol;
  } marked_byte_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_text_byte;
  logic       in_line_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_highlight;
  logic       out_last;

  meta_token_highlighter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_text_byte  (in_text_byte),
    .in_line_end   (in_line_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_highlight (out_highlight),
    .out_last      (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bytes waiting to be driven, the line being assembled, and the marked bytes that
  // the block still owes us.
  line_byte_t   stim_q[$];
  logic [7:0]   line_buf[$];
  marked_byte_t expect_q[$];
  marked_byte_t want;

  int bytes_queued   = 0;
  int lines_queued   = 0;
  int bytes_accepted = 0;
  int results_seen   = 0;
  int lit_seen       = 0;
  int mismatches     = 0;

  // Handshake bookkeeping between the sampling blocks and the drivers. The flags are
  // set at a rising edge and consumed at the following falling edge.
  bit in_taken  = 1'b0;
  bit in_loaded = 1'b0;
  bit in_burst  = 1'b0;
  int in_gap    = 0;
  bit out_taken = 1'b0;
  bit out_burst = 1'b0;
  int out_hold  = 0;

  // Scanner model state: the bytes whose flag is still open, a flag saying that we
  // are inside the run of an accepted token, the number of date bytes still to
  // report as marked, and whether the last reported byte was a space or the line
  // has only just begun.
  logic [7:0] held_bytes [0:LOOKAHEAD-1];
  logic [7:0] work_bytes [0:LOOKAHEAD];
  int         held_count;
  bit         in_run;
  int         date_left;
  bit         after_space;

  function automatic bit digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit run_char(input logic [7:0] c);
    return digit_char(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == CH_DASH || c == CH_UNDER;
  endfunction

  function automatic bit sigil_char(input logic [7:0] c);
    return c == CH_TILDE || c == CH_HASH || c == CH_AT;
  endfunction

  // Checks for the shape dddd-dd-dd starting at the given slot of the work window.
  function automatic bit date_at(input int at);
    int i;
    if (at + LOOKAHEAD - 1 > LOOKAHEAD) return 1'b0;
    for (i = 0; i < LOOKAHEAD; i++) begin
      if (i == 4 || i == 7) begin
        if (work_bytes[at + i] != CH_DASH) return 1'b0;
      end else if (!digit_char(work_bytes[at + i])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic clear_scan;
    held_count  = 0;
    in_run      = 1'b0;
    date_left   = 0;
    after_space = 1'b1;
  endtask

  // Adds one byte to the window and releases every byte whose flag is now settled.
  // On the final byte of a line the whole window is released, and the scan state
  // goes back to that of a fresh line.
  task automatic predict_highlight(input logic [7:0] ch, input logic eol);
    marked_byte_t found [0:LOOKAHEAD];
    int           n;
    int           head;
    int           got;
    int           i;
    logic [7:0]   c;
    bit           lit;
    bit           ready;
    bit           waiting;
    n = held_count;
    for (i = 0; i < n; i++) work_bytes[i] = held_bytes[i];
    work_bytes[n] = ch;
    n++;
    head    = 0;
    got     = 0;
    waiting = 1'b0;
    while (head < n && !waiting) begin
      c     = work_bytes[head];
      ready = 1'b1;
      lit   = 1'b0;
      if (date_left > 0) begin
        lit = 1'b1;
        date_left--;
      end else if (in_run) begin
        // A byte that breaks a token run is looked at again as a possible start.
        if (run_char(c)) lit = 1'b1;
        else begin
          in_run = 1'b0;
          ready  = 1'b0;
        end
      end else if (sigil_char(c)) begin
        if (n - head >= 2) begin
          lit    = run_char(work_bytes[head + 1]);
          in_run = lit;
        end else if (!eol) begin
          waiting = 1'b1;
          ready   = 1'b0;
        end
      end else if (digit_char(c) && after_space) begin
        if (n - head >= LOOKAHEAD + 1) begin
          lit = date_at(head) && work_bytes[head + LOOKAHEAD] == CH_SPACE;
        end else if (eol) begin
          lit = (n - head == LOOKAHEAD) && date_at(head);
        end else begin
          waiting = 1'b1;
          ready   = 1'b0;
        end
        if (lit) date_left = LOOKAHEAD - 1;
      end
      if (ready) begin
        found[got].ch  = c;
        found[got].lit = lit;
        found[got].eol = 1'b0;
        got++;
        after_space = (c == CH_SPACE);
        head++;
      end
    end
    held_count = n - head;
    for (i = 0; i < held_count; i++) held_bytes[i] = work_bytes[head + i];
    if (eol) begin
      found[got - 1].eol = 1'b1;
      clear_scan();
    end
    for (i = 0; i < got; i++) expect_q.push_back(found[i]);
  endtask

  // Stimulus helpers. A line is assembled in line_buf and then moved to the
  // pending queue with the line end flag on its final byte.
  task automatic flush_line;
    line_byte_t item;
    int         i;
    for (i = 0; i < line_buf.size(); i++) begin
      item.ch  = line_buf[i];
      item.eol = (i == line_buf.size() - 1);
      stim_q.push_back(item);
    end
    bytes_queued += line_buf.size();
    lines_queued++;
    line_buf.delete();
  endtask

  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    flush_line();
  endtask

  function automatic logic [7:0] pick_run_char;
    case ($urandom_range(0, 4))
      0:       return 8'(8'h30 + $urandom_range(0, 9));
      1:       return 8'(8'h61 + $urandom_range(0, 25));
      2:       return 8'(8'h41 + $urandom_range(0, 25));
      3:       return CH_DASH;
      default: return CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] pick_sigil;
    case ($urandom_range(0, 2))
      0:       return CH_TILDE;
      1:       return CH_HASH;
      default: return CH_AT;
    endcase
  endfunction

  task automatic add_run(input int len);
    int i;
    for (i = 0; i < len; i++) line_buf.push_back(pick_run_char());
  endtask

  // A date, now and then with one byte spoilt or cut short, so that near misses
  // and dates that run into the line end both turn up.
  task automatic add_date;
    int         i;
    int         spot;
    int         keep;
    bit         spoil;
    logic [7:0] d;
    spot  = $urandom_range(0, 9);
    spoil = ($urandom_range(0, 3) == 0);
    keep  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 10;
    for (i = 0; i < keep; i++) begin
      d = (i == 4 || i == 7) ? CH_DASH : 8'(8'h30 + $urandom_range(0, 9));
      if (spoil && i == spot) d = 8'($urandom_range(0, 255));
      line_buf.push_back(d);
    end
  endtask

  // Input side. A new byte is put on the port at the falling edge once the previous
  // one has been taken and its idle gap has run out. Long stretches without any gap
  // come from the burst flag, which flips now and then.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_taken  = 1'b0;
        in_loaded = 1'b0;
      end
      if (!in_loaded) begin
        if (in_gap != 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          in_text_byte <= stim_q[0].ch;
          in_line_end  <= stim_q[0].eol;
          in_valid     <= 1'b1;
          void'(stim_q.pop_front());
          in_loaded = 1'b1;
          if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Every input transaction is run through the model at the edge that takes it.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_highlight(in_text_byte, in_line_end);
      bytes_accepted++;
      in_taken = 1'b1;
    end
  end

  // Result side. Each result transaction draws a stall of its own; the stall only
  // counts down while a result is offered, so it always holds back a real result.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_hold = out_burst ? 0 : $urandom_range(0, 14);
      end
      out_stall <= (out_hold != 0);
      if (out_hold != 0 && out_valid) out_hold = out_hold - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      out_taken = 1'b1;
      results_seen++;
      if (out_highlight === 1'b1) lit_seen++;
      if (expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result %0d: byte %02h highlight %0b last %0b arrived with none expected",
                   results_seen, out_byte, out_highlight, out_last);
      end else begin
        want = expect_q.pop_front();
        if (out_byte !== want.ch || out_highlight !== want.lit || out_last !== want.eol) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d: expected byte %02h highlight %0b last %0b, got %02h %0b %0b",
                     results_seen, want.ch, want.lit, want.eol,
                     out_byte, out_highlight, out_last);
        end
      end
    end
  end

  initial begin
    int seg;
    int nseg;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_text_byte = 8'h00;
    in_line_end  = 1'b0;
    out_stall    = 1'b0;
    clear_scan();

    // Directed lines: a token that ends on a second sigil, a doubled sigil, a token
    // of letters and digits, a sigil standing alone as the whole line, a date that
    // fills the line exactly, a digit followed by the highest byte value, and the lowest
    // byte value followed by a sigil that the line end cuts short.
    queue_text("#_#-");
    queue_text("##a");
    queue_text("~Z9");
    queue_text("@");
    queue_text("1999-12-31");
    line_buf.push_back(8'h37);
    line_buf.push_back(8'hFF);
    flush_line();
    line_buf.push_back(8'h00);
    line_buf.push_back(CH_TILDE);
    flush_line();

    // Random lines built from tokens, dates, words, spaces and noise bytes.
    while (bytes_queued < 420) begin
      nseg = $urandom_range(1, 5);
      for (seg = 0; seg < nseg; seg++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            line_buf.push_back(pick_sigil());
            add_run($urandom_range(1, 5));
          end
          2: line_buf.push_back(pick_sigil());
          3, 4: begin
            line_buf.push_back(CH_SPACE);
            add_date();
          end
          5: add_date();
          6: add_run($urandom_range(1, 6));
          7, 9: line_buf.push_back(CH_SPACE);
          default: repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      flush_line();
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (bytes_accepted == bytes_queued);
    while (expect_q.size() != 0) @(posedge clk);
    // The block may still be draining; give it time to show any stray result.
    repeat (40) @(posedge clk);

    $display("Streamed %0d lines, %0d bytes in all; %0d results came back, %0d highlighted.",
             lines_queued, bytes_accepted, results_seen, lit_seen);
    if (mismatches == 0 && expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Safety net: a correct run ends well inside this time.
  initial begin
    #10_000_000;
    $display("Timed out with %0d results still outstanding", expect_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
